FILE: hw/rtl/pcnt_pkg.sv
// ---------------------------------------------------------------------------
// pcnt_pkg
// Shared widths, constants and controller/datapath interface types for the
// odd-only bit-packed sieve prime counter.
// ---------------------------------------------------------------------------
package pcnt_pkg;

    localparam int BOUND_W = 21;
    localparam int COUNT_W = 17;
    localparam int DATA_W  = 24;                // tdata width, whole bytes
    localparam int WORD_W  = 32;                // odd numbers per store word
    localparam int SEL_W   = 5;                 // bit select within a word
    localparam int FACT_W  = 11;                // f*f <= top < 2**21 keeps f below 2048
    localparam int MULT_W  = 2 * FACT_W;        // room for f*f and a multiple plus 2f
    localparam int MAXN_W  = 33;

    localparam logic [MAXN_W-1:0] MAX_N = 33'd1048576;

    typedef struct packed {
        logic load;         // latch bound, top, last word; f = 3, k = 0
        logic clr_step;     // write cleared word k, k++
        logic fact_rd;      // read the word holding factor f
        logic fact_next;    // f += 2
        logic mark_start;   // multiple = f*f
        logic mark_issue;   // read word of multiple, multiple += 2f
        logic cnt_start;    // k = 0, count = 1
        logic cnt_issue;    // read word k for counting, k++
        logic out_load;     // load result payload
    } cmd_t;

    typedef struct packed {
        logic skip;         // bound out of range or below two
        logic k_last;       // word counter at last word in use
        logic sq_over;      // f*f > top
        logic fact_marked;  // factor f already marked composite
        logic mark_last;    // next multiple passes top
    } sts_t;

endpackage

FILE: hw/rtl/pcnt_ctrl.sv
// ---------------------------------------------------------------------------
// pcnt_ctrl
// Sequencer for the sieve: clear pass, factor loop with marking, counting
// pass, and the result register handshake.
// ---------------------------------------------------------------------------
module pcnt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  pcnt_pkg::sts_t sts,
    output pcnt_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FSQ,
        ST_FTEST,
        ST_FREAD,
        ST_MARK,
        ST_DRAIN,
        ST_COUNT,
        ST_CDRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.skip ? ST_DONE : ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.k_last)
                    state_next = ST_FSQ;
            end
            ST_FSQ:
            begin
                state_next = ST_FTEST;
            end
            ST_FTEST:
            begin
                if (sts.sq_over)
                begin
                    cmd.cnt_start = 1'b1;
                    state_next    = ST_COUNT;
                end
                else
                begin
                    cmd.fact_rd = 1'b1;
                    state_next  = ST_FREAD;
                end
            end
            ST_FREAD:
            begin
                if (sts.fact_marked)
                begin
                    cmd.fact_next = 1'b1;
                    state_next    = ST_FSQ;
                end
                else
                begin
                    cmd.mark_start = 1'b1;
                    state_next     = ST_MARK;
                end
            end
            ST_MARK:
            begin
                cmd.mark_issue = 1'b1;
                if (sts.mark_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // last marking write lands this cycle
                cmd.fact_next = 1'b1;
                state_next    = ST_FSQ;
            end
            ST_COUNT:
            begin
                cmd.cnt_issue = 1'b1;
                if (sts.k_last)
                    state_next = ST_CDRAIN;
            end
            ST_CDRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

FILE: hw/rtl/pcnt_dp.sv
// ---------------------------------------------------------------------------
// pcnt_dp
// Sieve datapath: composite word store, factor and multiple registers,
// read-modify-write marking pipe with forwarding, zero-bit counter.
// ---------------------------------------------------------------------------
module pcnt_dp
#(
    parameter logic [pcnt_pkg::MAXN_W-1:0] MAX_N = pcnt_pkg::MAX_N
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pcnt_pkg::BOUND_W-1:0]  bound,
    input  pcnt_pkg::cmd_t                cmd,
    output pcnt_pkg::sts_t                sts,
    output logic [pcnt_pkg::COUNT_W-1:0]  prime_count,
    output logic                          out_of_range
);

    localparam int    BOUND_W = pcnt_pkg::BOUND_W;
    localparam int    COUNT_W = pcnt_pkg::COUNT_W;
    localparam int    WORD_W  = pcnt_pkg::WORD_W;
    localparam int    SEL_W   = pcnt_pkg::SEL_W;
    localparam int    FACT_W  = pcnt_pkg::FACT_W;
    localparam int    MULT_W  = pcnt_pkg::MULT_W;
    localparam int    NW      = pcnt_pkg::MAXN_W;
    localparam longint STORE_WORDS = ((longint'(MAX_N) - 1) >> 6) + 1;
    localparam int    ADDR_W  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    function automatic logic [SEL_W:0] zeros32(input logic [WORD_W-1:0] w);
        logic [SEL_W:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++)
            n = n + {{SEL_W{1'b0}}, ~w[i]};
        return n;
    endfunction

    logic [WORD_W-1:0]  mem [0:STORE_WORDS-1];
    logic [WORD_W-1:0]  rdata_reg;
    logic [ADDR_W-1:0]  raddr;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [WORD_W-1:0]  wdata;

    logic [BOUND_W-1:0] top_reg;
    logic [BOUND_W-1:0] bound_top;
    logic [ADDR_W-1:0]  last_reg;
    logic [ADDR_W-1:0]  k_reg;
    logic [FACT_W-1:0]  f_reg;
    logic [MULT_W-1:0]  sq_reg;
    logic [MULT_W-1:0]  m_reg;
    logic [MULT_W-1:0]  step;
    logic [MULT_W-1:0]  m_next;
    logic [COUNT_W-1:0] count_reg;
    logic               zero_reg;
    logic               oor_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_oor_reg;

    logic               p_valid_reg;
    logic [ADDR_W-1:0]  p_addr_reg;
    logic [SEL_W-1:0]   p_sel_reg;
    logic               c_valid_reg;
    logic               lw_valid_reg;
    logic [ADDR_W-1:0]  lw_addr_reg;
    logic [WORD_W-1:0]  lw_data_reg;
    logic [WORD_W-1:0]  mark_base;
    logic [WORD_W-1:0]  clr_word;

    assign bound_top = bound[0] ? bound : bound - 1'b1;
    assign step      = MULT_W'({f_reg, 1'b0});
    assign m_next    = m_reg + step;

    assign sts.skip        = (NW'(bound) > MAX_N) || (bound < BOUND_W'(2));
    assign sts.k_last      = (k_reg == last_reg);
    assign sts.sq_over     = (sq_reg > MULT_W'(top_reg));
    assign sts.fact_marked = rdata_reg[f_reg[SEL_W:1]];
    assign sts.mark_last   = (m_next > MULT_W'(top_reg));

    // read port: marking multiple, factor test or counting sweep
    always_comb
    begin
        if (cmd.mark_issue)
            raddr = ADDR_W'(m_reg >> 6);
        else if (cmd.fact_rd)
            raddr = ADDR_W'(f_reg >> 6);
        else
            raddr = k_reg;
    end

    // back-to-back hits on one word see the previous write, not the stale read
    assign mark_base = (lw_valid_reg && lw_addr_reg == p_addr_reg) ? lw_data_reg : rdata_reg;

    always_comb
    begin
        clr_word = '0;
        if (k_reg == last_reg)
            clr_word = 32'hFFFF_FFFE << top_reg[SEL_W:1];
        if (k_reg == '0)
            clr_word = clr_word | 32'h0000_0001;
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = k_reg;
        wdata = clr_word;
        if (p_valid_reg)
        begin
            we    = 1'b1;
            waddr = p_addr_reg;
            wdata = mark_base | (32'h0000_0001 << p_sel_reg);
        end
        else if (cmd.clr_step)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
            top_reg      <= '0;
            last_reg     <= '0;
            k_reg        <= '0;
            f_reg        <= '0;
            sq_reg       <= '0;
            m_reg        <= '0;
            count_reg    <= '0;
            zero_reg     <= 1'b0;
            oor_reg      <= 1'b0;
        end
        else
        begin
            p_valid_reg <= cmd.mark_issue;
            c_valid_reg <= cmd.cnt_issue;
            if (we)
                lw_valid_reg <= 1'b1;
            sq_reg <= MULT_W'(f_reg) * MULT_W'(f_reg);

            if (cmd.load)
            begin
                top_reg  <= bound_top;
                last_reg <= ADDR_W'(bound_top >> 6);
                k_reg    <= '0;
                f_reg    <= FACT_W'(3);
                zero_reg <= sts.skip;
                oor_reg  <= NW'(bound) > MAX_N;
            end
            if (cmd.clr_step || cmd.cnt_issue)
                k_reg <= k_reg + 1'b1;
            if (cmd.cnt_start)
            begin
                k_reg     <= '0;
                count_reg <= COUNT_W'(1);   // the prime two
            end
            if (cmd.fact_next)
                f_reg <= f_reg + FACT_W'(2);
            if (cmd.mark_start)
                m_reg <= sq_reg;
            if (cmd.mark_issue)
                m_reg <= m_next;
            if (c_valid_reg)
                count_reg <= count_reg + COUNT_W'(zeros32(rdata_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_issue)
        begin
            p_addr_reg <= ADDR_W'(m_reg >> 6);
            p_sel_reg  <= m_reg[SEL_W:1];
        end
        if (we)
        begin
            lw_addr_reg <= waddr;
            lw_data_reg <= wdata;
        end
        if (cmd.out_load)
        begin
            out_count_reg <= zero_reg ? '0 : count_reg;
            out_oor_reg   <= oor_reg;
        end
    end

    assign prime_count  = out_count_reg;
    assign out_of_range = out_oor_reg;

endmodule

FILE: hw/rtl/prime_count_bitpacked_odd_sieve.sv
// ---------------------------------------------------------------------------
// prime_count_bitpacked_odd_sieve
// Counts the primes not above a bound with an odd-only bit-packed sieve.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel carries one request: the bound in s_tdata[20:0]. The
//   master channel returns the prime count in m_tdata[16:0] and the
//   out-of-range flag in m_tuser. One request is in work at a time;
//   s_tready is high only while the sieve is idle.
//   Sequence: a bound above MAX_N or below two skips the sieve and goes
//   straight to the result. Otherwise W = top/64 + 1 store words are
//   cleared, each odd factor f with f*f <= top is tested, and an unmarked
//   one has its multiples from f*f up to top marked through the
//   read-modify-write pipe of the word store; the first factor with
//   f*f > top ends the loop, then a counting sweep adds up the unmarked
//   bits of the W words and the result is presented.
//   The result sits in an output register; a new request is taken while it
//   waits, and a finished run holds until the register frees up.
//   Reset clears the controller and empties the output; the word store is
//   cleared at the start of every run that sieves instead.
// ---------------------------------------------------------------------------
module prime_count_bitpacked_odd_sieve
#(
    parameter logic [pcnt_pkg::MAXN_W-1:0] MAX_N = pcnt_pkg::MAX_N
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pcnt_pkg::DATA_W-1:0] s_tdata,   // [20:0] bound
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pcnt_pkg::DATA_W-1:0] m_tdata,   // [16:0] prime_count
    output logic [0:0]                  m_tuser    // [0] out_of_range
);

    pcnt_pkg::cmd_t                   cmd;
    pcnt_pkg::sts_t                   sts;
    logic [pcnt_pkg::COUNT_W-1:0]     prime_count;
    logic                             out_of_range;

    pcnt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcnt_dp #(
        .MAX_N (MAX_N)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .bound        (s_tdata[pcnt_pkg::BOUND_W-1:0]),
        .cmd          (cmd),
        .sts          (sts),
        .prime_count  (prime_count),
        .out_of_range (out_of_range)
    );

    assign m_tdata = pcnt_pkg::DATA_W'(prime_count);
    assign m_tuser = out_of_range;

    // result register only loads when it is empty or being drained
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over an unread result");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("out-of-range result with non-zero count");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while a run is in progress");

    a_mark_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_issue |-> !(cmd.clr_step || cmd.cnt_issue || cmd.fact_rd))
        else $error("marking overlaps another store access");

endmodule

FILE: verif/prime_count_bitpacked_odd_sieve_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prime_count_bitpacked_odd_sieve_tb
// Sends bounds to the prime counter and checks each returned count and
// range flag. A short table of edge-case bounds comes first, then randomised
// bounds, mostly small. Each result not typed into the table is compared
// with a local odd-only sieve. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module prime_count_bitpacked_odd_sieve_tb;

    localparam int STORE_WORDS     = 16384;
    localparam int RANDOM_REQUESTS = 100;
    localparam int WATCHDOG_LIMIT  = 6000000;
    localparam int IDLE_PCT        = 38;

    typedef struct packed {
        logic [pcnt_pkg::COUNT_W-1:0] prime_count;
        logic                         out_of_range;
    } tally_t;

    typedef struct packed {
        logic [pcnt_pkg::BOUND_W-1:0] bound;
        logic                         known;      // tally typed in; otherwise predicted
        tally_t                       tally;
    } probe_t;

    localparam tally_t FROM_SIEVE  = '0;
    localparam tally_t NO_PRIMES   = '{prime_count: '0, out_of_range: 1'b0};
    localparam tally_t OVER_RANGE  = '{prime_count: '0, out_of_range: 1'b1};

    localparam int DIRECTED_ROWS = 17;

    // bound, known, tally
    localparam probe_t DIRECTED_PROBES [DIRECTED_ROWS] = '{
        '{21'd0,       1'b1, NO_PRIMES},                    // below two
        '{21'd1,       1'b1, NO_PRIMES},
        '{21'd2,       1'b1, '{17'd1, 1'b0}},               // only the prime 2
        '{21'd3,       1'b0, FROM_SIEVE},
        '{21'd4,       1'b0, FROM_SIEVE},                   // even bound
        '{21'd9,       1'b0, FROM_SIEVE},                   // first odd square
        '{21'd25,      1'b0, FROM_SIEVE},
        '{21'd63,      1'b0, FROM_SIEVE},                   // top in last bit of word 0
        '{21'd64,      1'b0, FROM_SIEVE},
        '{21'd65,      1'b0, FROM_SIEVE},                   // first bit of word 1
        '{21'd127,     1'b0, FROM_SIEVE},
        '{21'd128,     1'b0, FROM_SIEVE},
        '{21'd1000,    1'b0, FROM_SIEVE},
        '{21'd1048577, 1'b1, OVER_RANGE},                   // just above MAX_N
        '{21'd2097151, 1'b1, OVER_RANGE},                   // all bits set
        '{21'd1048576, 1'b1, '{17'd82025, 1'b0}},           // MAX_N itself
        '{21'd0,       1'b1, NO_PRIMES}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [pcnt_pkg::DATA_W-1:0]   s_tdata = '0;       // [20:0] bound
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pcnt_pkg::DATA_W-1:0]   m_tdata;            // [16:0] prime_count
    logic [0:0]                    m_tuser;            // [0] out_of_range

    tally_t                        expected_tallies [$];
    logic [pcnt_pkg::WORD_W-1:0]   sieve_words [STORE_WORDS];
    int                            mismatches = 0;
    int                            quiet_cycles = 0;
    bit                            steady = 1'b0;      // no idling on either side

    prime_count_bitpacked_odd_sieve uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Odd-only sieve: bit (v & 63) >> 1 of word v >> 6 marks odd v composite.
    function automatic tally_t predict_tally(input logic [pcnt_pkg::BOUND_W-1:0] bound);
        tally_t      t;
        int unsigned top;
        int unsigned words;
        int unsigned f;
        int unsigned m;
        int unsigned count;
        t = NO_PRIMES;
        if (bound > pcnt_pkg::MAX_N)
        begin
            t.out_of_range = 1'b1;
        end
        else if (bound >= 2)
        begin
            top   = bound[0] ? bound : bound - 1;
            words = (top >> 6) + 1;
            for (int k = 0; k < words; k++)
                sieve_words[k] = '0;
            // odd numbers past top never count, nor does one
            sieve_words[words - 1] = 32'hFFFF_FFFE << ((top & 63) >> 1);
            sieve_words[0][0] = 1'b1;
            for (f = 3; f * f <= top; f += 2)
            begin
                if (!sieve_words[f >> 6][(f & 63) >> 1])
                begin
                    for (m = f * f; m <= top; m += 2 * f)
                        sieve_words[m >> 6][(m & 63) >> 1] = 1'b1;
                end
            end
            count = 1;
            for (int k = 0; k < words; k++)
                count += $countones(~sieve_words[k]);
            t.prime_count = count[pcnt_pkg::COUNT_W-1:0];
        end
        return t;
    endfunction

    function automatic logic [pcnt_pkg::BOUND_W-1:0] random_bound();
        int unsigned pick;
        int unsigned value;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            value = $urandom_range(0, 3);
        else if (pick < 60)
            value = $urandom_range(4, 300);
        else if (pick < 82)
            value = $urandom_range(301, 4095);
        else if (pick < 85)
            value = $urandom_range(4096, 40000);
        else if (pick < 97)
            value = $urandom_range(32'(pcnt_pkg::MAX_N) + 1,
                                   (1 << pcnt_pkg::BOUND_W) - 1);
        else
            value = $urandom_range(2, 64);
        return pcnt_pkg::BOUND_W'(value);
    endfunction

    task automatic send_request(input logic [pcnt_pkg::BOUND_W-1:0] bound,
                                input tally_t want);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(pcnt_pkg::DATA_W - pcnt_pkg::BOUND_W){1'b0}}, bound};
        do
            @(posedge clk);
        while (!s_tready);
        expected_tallies.push_back(want);
    endtask

    task automatic drain_results();
        while (expected_tallies.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [pcnt_pkg::BOUND_W-1:0] bound;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PROBES[i])
        begin
            if (DIRECTED_PROBES[i].known)
                send_request(DIRECTED_PROBES[i].bound, DIRECTED_PROBES[i].tally);
            else
                send_request(DIRECTED_PROBES[i].bound,
                             predict_tally(DIRECTED_PROBES[i].bound));
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // hold off now and then until every request has been answered
            if (n % 30 == 0)
            begin
                s_tvalid <= 1'b0;
                drain_results();
            end
            steady = (n >= 40 && n < 65);
            bound  = random_bound();
            send_request(bound, predict_tally(bound));
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        drain_results();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("prime_count_bitpacked_odd_sieve_tb: done, clean");
        else
            $display("prime_count_bitpacked_odd_sieve_tb: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin : result_check
        tally_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_tallies.size() == 0)
            begin
                $error("result with no request outstanding: prime_count %0d",
                       m_tdata[pcnt_pkg::COUNT_W-1:0]);
                mismatches++;
            end
            else
            begin
                want = expected_tallies.pop_front();
                if (m_tdata[pcnt_pkg::COUNT_W-1:0] !== want.prime_count)
                begin
                    $error("prime_count: expected %0d, got %0d",
                           want.prime_count, m_tdata[pcnt_pkg::COUNT_W-1:0]);
                    mismatches++;
                end
                if (m_tuser[0] !== want.out_of_range)
                begin
                    $error("out_of_range: expected %0b, got %0b",
                           want.out_of_range, m_tuser[0]);
                    mismatches++;
                end
            end
        end
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("prime_count_bitpacked_odd_sieve_tb: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
